>>> rtl/mffp_pkg.sv
`default_nettype none

package mffp_pkg;

  // frame delimiters
  localparam logic [7:0] HEADER_BYTE = 8'd126;
  localparam logic [7:0] TAIL_BYTE   = 8'd127;

  // configuration register map
  localparam int unsigned CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] CFG_X_ADDR      = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_Y_ADDR      = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SPEED_CODE  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_MULTI_CODE  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_SINGLE_CODE = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_ACCEL_CODE  = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_VOLT_CODE   = 3'd6;

  // configuration reset values
  localparam logic [7:0] RST_X_ADDR      = 8'd1;
  localparam logic [7:0] RST_Y_ADDR      = 8'd2;
  localparam logic [7:0] RST_SPEED_CODE  = 8'd1;
  localparam logic [7:0] RST_MULTI_CODE  = 8'd2;
  localparam logic [7:0] RST_SINGLE_CODE = 8'd3;
  localparam logic [7:0] RST_ACCEL_CODE  = 8'd4;
  localparam logic [7:0] RST_VOLT_CODE   = 8'd5;

  // value bytes per frame, minus one
  localparam logic [1:0] VALUE_LAST_CNT = 2'd3;

  localparam int unsigned IN_W  = 8;
  localparam int unsigned REC_W = 137;
  localparam int unsigned OUT_W = 144;

  typedef enum logic [2:0] {
    PH_HEADER = 3'd0,
    PH_ADDR   = 3'd1,
    PH_TYPE   = 3'd2,
    PH_VALUE  = 3'd3,
    PH_CKSUM  = 3'd4,
    PH_TAIL   = 3'd5
  } phase_t;

  typedef struct packed {
    logic [7:0] x_addr;
    logic [7:0] y_addr;
    logic [7:0] speed_code;
    logic [7:0] multi_code;
    logic [7:0] single_code;
    logic [7:0] accel_code;
    logic [7:0] volt_code;
  } cfg_t;

  // a good frame, valid in the cycle its tail byte is taken
  typedef struct packed {
    logic        valid;
    logic        axis;
    logic [7:0]  type_code;
    logic [31:0] raw_value;
  } frame_t;

  // output record, lowest field last
  typedef struct packed {
    logic [15:0] voltage_now;
    logic [15:0] accel_now;
    logic [15:0] single_angle_now;
    logic [31:0] multi_angle_now;
    logic [15:0] speed_now;
    logic [31:0] raw_value;
    logic [7:0]  type_code;
    logic        axis;
  } rec_t;

endpackage

`default_nettype wire

>>> rtl/mffp_parser.sv
`default_nettype none

module mffp_parser import mffp_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       byte_fire,
  input  wire logic [7:0] rx_byte,
  input  wire cfg_t       cfg,
  output frame_t          frame
);

  phase_t      phase_r, phase_nxt;
  logic [7:0]  addr_r;
  logic [7:0]  type_r;
  logic [31:0] val_r;
  logic [7:0]  xor_r;
  logic [7:0]  cks_r;
  logic [1:0]  vcnt_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_HEADER;
    end else if (byte_fire) begin
      phase_r <= phase_nxt;
    end
  end

  always_comb begin
    phase_nxt = PH_HEADER;
    unique case (phase_r)
      PH_HEADER: phase_nxt = (rx_byte == HEADER_BYTE) ? PH_ADDR : PH_HEADER;
      PH_ADDR: begin
        phase_nxt = (rx_byte == cfg.x_addr || rx_byte == cfg.y_addr) ? PH_TYPE : PH_HEADER;
      end
      PH_TYPE:  phase_nxt = (rx_byte <= cfg.volt_code) ? PH_VALUE : PH_HEADER;
      PH_VALUE: phase_nxt = (vcnt_r == VALUE_LAST_CNT) ? PH_CKSUM : PH_VALUE;
      PH_CKSUM: phase_nxt = PH_TAIL;
      PH_TAIL:  phase_nxt = PH_HEADER;
      default:  phase_nxt = PH_HEADER;
    endcase
  end

  // frame fields and running checksum; no reset, each is loaded before use
  always_ff @(posedge clk) begin
    if (byte_fire) begin
      unique case (phase_r)
        PH_HEADER: xor_r <= rx_byte;
        PH_ADDR: begin
          addr_r <= rx_byte;
          xor_r  <= xor_r ^ rx_byte;
        end
        PH_TYPE: begin
          type_r <= rx_byte;
          xor_r  <= xor_r ^ rx_byte;
          vcnt_r <= '0;
        end
        PH_VALUE: begin
          val_r  <= {val_r[23:0], rx_byte};
          xor_r  <= xor_r ^ rx_byte;
          vcnt_r <= vcnt_r + 2'd1;
        end
        PH_CKSUM: cks_r <= rx_byte;
        default: ;
      endcase
    end
  end

  always_comb begin
    frame.valid     = byte_fire && (phase_r == PH_TAIL) && (rx_byte == TAIL_BYTE)
                      && (xor_r == cks_r);
    // equal addresses resolve to X
    frame.axis      = (addr_r == cfg.x_addr) ? 1'b0 : 1'b1;
    frame.type_code = type_r;
    frame.raw_value = val_r;
  end

endmodule

`default_nettype wire

>>> rtl/mffp_record.sv
`default_nettype none

module mffp_record import mffp_pkg::*; (
  input  wire logic   clk,
  input  wire logic   rst_n,
  input  wire cfg_t   cfg,
  input  wire frame_t frame,
  output logic        advance,
  output logic        rec_valid,
  input  wire logic   rec_ready,
  output rec_t        rec
);

  logic [15:0] speed_r  [2];
  logic [31:0] multi_r  [2];
  logic [15:0] single_r [2];
  logic [15:0] accel_r  [2];
  logic [15:0] volt_r   [2];

  logic        out_valid_r;
  rec_t        out_r;
  rec_t        rec_nxt;
  logic        ax;
  logic        upd_speed, upd_multi, upd_single, upd_accel, upd_volt;

  assign advance   = !out_valid_r || rec_ready;
  assign rec_valid = out_valid_r;
  assign rec       = out_r;
  assign ax        = frame.axis;

  // first matching code wins
  always_comb begin
    upd_speed  = 1'b0;
    upd_multi  = 1'b0;
    upd_single = 1'b0;
    upd_accel  = 1'b0;
    upd_volt   = 1'b0;
    if (frame.type_code == cfg.speed_code) begin
      upd_speed = 1'b1;
    end else if (frame.type_code == cfg.multi_code) begin
      upd_multi = 1'b1;
    end else if (frame.type_code == cfg.single_code) begin
      upd_single = 1'b1;
    end else if (frame.type_code == cfg.accel_code) begin
      upd_accel = 1'b1;
    end else if (frame.type_code == cfg.volt_code) begin
      upd_volt = 1'b1;
    end
  end

  always_comb begin
    rec_nxt.axis             = ax;
    rec_nxt.type_code        = frame.type_code;
    rec_nxt.raw_value        = frame.raw_value;
    rec_nxt.speed_now        = upd_speed  ? frame.raw_value[15:0] : speed_r[ax];
    rec_nxt.multi_angle_now  = upd_multi  ? frame.raw_value       : multi_r[ax];
    rec_nxt.single_angle_now = upd_single ? frame.raw_value[15:0] : single_r[ax];
    rec_nxt.accel_now        = upd_accel  ? frame.raw_value[15:0] : accel_r[ax];
    rec_nxt.voltage_now      = upd_volt   ? frame.raw_value[15:0] : volt_r[ax];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 2; i++) begin
        speed_r[i]  <= '0;
        multi_r[i]  <= '0;
        single_r[i] <= '0;
        accel_r[i]  <= '0;
        volt_r[i]   <= '0;
      end
    end else if (frame.valid) begin
      speed_r[ax]  <= rec_nxt.speed_now;
      multi_r[ax]  <= rec_nxt.multi_angle_now;
      single_r[ax] <= rec_nxt.single_angle_now;
      accel_r[ax]  <= rec_nxt.accel_now;
      volt_r[ax]   <= rec_nxt.voltage_now;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= frame.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (frame.valid) begin
      out_r <= rec_nxt;
    end
  end

endmodule

`default_nettype wire

>>> rtl/motor_feedback_frame_parser_core.sv
`default_nettype none

// Channel | Dir | Ports                        | Content
// in_     | in  | tvalid tready tdata[7:0]     | one received serial byte
// out_    | out | tvalid tready tdata[143:0]   | axis record of a good frame
// cfg_    | in  | we index[2:0] wdata[7:0]     | addresses and type codes
//
// One byte request per cycle while in_tready is high. A byte waits in the input register,
// then the parser and record update take it; the record of a good frame shows
// on out_ the cycle after its tail byte is parsed.
// Sync active-low reset clears phase, stores and valids and loads the config registers with their reset values.
// A stalled output holds both stages; in_tready drops only while a record
// waits and the input register is full.
module motor_feedback_frame_parser_core import mffp_pkg::*; (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_tvalid,
  output logic                  in_tready,
  input  wire logic [IN_W-1:0]  in_tdata,   // [7:0] rx_byte
  output logic                  out_tvalid,
  input  wire logic             out_tready,
  // [0] axis, [8:1] type_code, [40:9] raw_value, [56:41] speed_now,
  // [88:57] multi_angle_now, [104:89] single_angle_now,
  // [120:105] accel_now, [136:121] voltage_now, [143:137] zero
  output logic [OUT_W-1:0]      out_tdata,
  input  wire logic             cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [7:0]       cfg_wdata
);

  cfg_t       cfg_r;
  logic       in_valid_r;
  logic [7:0] in_byte_r;
  logic       advance;
  logic       byte_fire;
  frame_t     frm;
  rec_t       rec;

  // config registers, written without handshake
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.x_addr      <= RST_X_ADDR;
      cfg_r.y_addr      <= RST_Y_ADDR;
      cfg_r.speed_code  <= RST_SPEED_CODE;
      cfg_r.multi_code  <= RST_MULTI_CODE;
      cfg_r.single_code <= RST_SINGLE_CODE;
      cfg_r.accel_code  <= RST_ACCEL_CODE;
      cfg_r.volt_code   <= RST_VOLT_CODE;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_X_ADDR:      cfg_r.x_addr      <= cfg_wdata;
        CFG_Y_ADDR:      cfg_r.y_addr      <= cfg_wdata;
        CFG_SPEED_CODE:  cfg_r.speed_code  <= cfg_wdata;
        CFG_MULTI_CODE:  cfg_r.multi_code  <= cfg_wdata;
        CFG_SINGLE_CODE: cfg_r.single_code <= cfg_wdata;
        CFG_ACCEL_CODE:  cfg_r.accel_code  <= cfg_wdata;
        CFG_VOLT_CODE:   cfg_r.volt_code   <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // input register stage
  assign byte_fire = in_valid_r && advance;
  assign in_tready = !in_valid_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_tready) begin
      in_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      in_byte_r <= in_tdata;
    end
  end

  mffp_parser u_parser (
    .clk       (clk),
    .rst_n     (rst_n),
    .byte_fire (byte_fire),
    .rx_byte   (in_byte_r),
    .cfg       (cfg_r),
    .frame     (frm)
  );

  mffp_record u_record (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .frame     (frm),
    .advance   (advance),
    .rec_valid (out_tvalid),
    .rec_ready (out_tready),
    .rec       (rec)
  );

  assign out_tdata = {{(OUT_W - REC_W){1'b0}}, rec};

  // a good frame always lands in the output register
  a_frame_to_out: assert property (@(posedge clk) disable iff (!rst_n)
    frm.valid |=> out_tvalid)
    else $error("good frame did not produce a record");

  // input side backs up only behind a stalled record
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> (out_tvalid && !out_tready))
    else $error("input stalled without output backpressure");

  // a fresh record comes only from a parsed byte
  a_rec_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> $past(byte_fire))
    else $error("record appeared without a parsed byte");

endmodule

`default_nettype wire

>>> tb/motor_feedback_frame_parser_core_tb.sv
module motor_feedback_frame_parser_core_tb import mffp_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  // run length and safety net
  localparam int TOTAL_BYTES  = 1050;
  localparam int CFG_EVERY    = 200;   // bytes between random register sets
  localparam int STALL_CYCLES = 300;   // long receiver hold-off
  localparam int DRAIN_CYCLES = 8;     // extra wait once every record is checked
  localparam int LIMIT_CYCLES = 200000;

  logic                 clk        = 1'b0;
  logic                 rst_n      = 1'b0;
  logic                 in_tvalid  = 1'b0;
  logic                 in_tready;
  logic [IN_W-1:0]      in_tdata   = '0;   // [7:0] rx_byte
  logic                 out_tvalid;
  logic                 out_tready = 1'b0;
  // [0] axis, [8:1] type_code, [40:9] raw_value, [56:41] speed_now,
  // [88:57] multi_angle_now, [104:89] single_angle_now,
  // [120:105] accel_now, [136:121] voltage_now, [143:137] zero
  logic [OUT_W-1:0]     out_tdata;
  logic                 cfg_we     = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index  = CFG_X_ADDR;
  logic [7:0]           cfg_wdata  = '0;

  // testbench control
  int err_cnt    = 0;
  int bytes_sent = 0;
  int cycle_cnt  = 0;
  int stall_req  = 0;     // set by a test, picked up by the receiver
  bit no_gaps    = 1'b0;  // both sides run without idling while set

  // shadow of the parser: registers, frame state, per-axis stores
  cfg_t        regs;
  phase_t      rx_phase;
  logic [3:0]  rx_pos;
  logic [7:0]  frame_buf [8];
  logic [15:0] speed_mem [2];
  logic [31:0] multi_mem [2];
  logic [15:0] single_mem [2];
  logic [15:0] accel_mem [2];
  logic [15:0] volt_mem [2];

  // records of good frames, oldest first
  rec_t pending_records [$];

  motor_feedback_frame_parser_core dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  always #1 clk = ~clk;

  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt >= LIMIT_CYCLES) begin
      $display("%0t ns: timeout after %0d cycles", $time, cycle_cnt);
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Shadow parser
  // ---------------------------------------------------------------------------

  function automatic void clear_shadow();
    regs = '{x_addr: RST_X_ADDR, y_addr: RST_Y_ADDR, speed_code: RST_SPEED_CODE,
             multi_code: RST_MULTI_CODE, single_code: RST_SINGLE_CODE,
             accel_code: RST_ACCEL_CODE, volt_code: RST_VOLT_CODE};
    rx_phase = PH_HEADER;
    rx_pos   = '0;
    for (int i = 0; i < 8; i++) frame_buf[i] = '0;
    for (int a = 0; a < 2; a++) begin
      speed_mem[a]  = '0;
      multi_mem[a]  = '0;
      single_mem[a] = '0;
      accel_mem[a]  = '0;
      volt_mem[a]   = '0;
    end
  endfunction

  function automatic void keep_byte(logic [7:0] b);
    frame_buf[rx_pos[2:0]] = b;
    rx_pos = rx_pos + 4'd1;
  endfunction

  // Advance the shadow by one accepted byte; a good tail queues one record.
  function automatic void parse_rx_byte(logic [7:0] b);
    logic [7:0]  sum;
    logic [31:0] val;
    logic        ax;
    rec_t        r;
    case (rx_phase)
      PH_HEADER: begin
        if (b == HEADER_BYTE) begin
          frame_buf[0] = b;
          rx_pos   = 4'd1;
          rx_phase = PH_ADDR;
        end
      end
      PH_ADDR: begin
        if (b == regs.x_addr || b == regs.y_addr) begin
          keep_byte(b);
          rx_phase = PH_TYPE;
        end else begin
          rx_phase = PH_HEADER;
        end
      end
      PH_TYPE: begin
        // anything above the voltage code drops the frame
        if (b <= regs.volt_code) begin
          keep_byte(b);
          rx_phase = PH_VALUE;
        end else begin
          rx_phase = PH_HEADER;
        end
      end
      PH_VALUE: begin
        keep_byte(b);
        if (rx_pos >= 4'd7) rx_phase = PH_CKSUM;
      end
      PH_CKSUM: begin
        keep_byte(b);
        rx_phase = PH_TAIL;
      end
      PH_TAIL: begin
        // tail byte is consumed either way, never taken as a new header
        rx_phase = PH_HEADER;
        rx_pos   = '0;
        sum = '0;
        for (int i = 0; i < 7; i++) sum ^= frame_buf[i];
        if (b == TAIL_BYTE && sum == frame_buf[7]) begin
          // equal addresses resolve to X
          ax  = (frame_buf[1] == regs.x_addr) ? 1'b0 : 1'b1;
          val = {frame_buf[3], frame_buf[4], frame_buf[5], frame_buf[6]};
          // first matching code wins; no match leaves the stores alone
          if (frame_buf[2] == regs.speed_code)       speed_mem[ax]  = val[15:0];
          else if (frame_buf[2] == regs.multi_code)  multi_mem[ax]  = val;
          else if (frame_buf[2] == regs.single_code) single_mem[ax] = val[15:0];
          else if (frame_buf[2] == regs.accel_code)  accel_mem[ax]  = val[15:0];
          else if (frame_buf[2] == regs.volt_code)   volt_mem[ax]   = val[15:0];
          r.axis             = ax;
          r.type_code        = frame_buf[2];
          r.raw_value        = val;
          r.speed_now        = speed_mem[ax];
          r.multi_angle_now  = multi_mem[ax];
          r.single_angle_now = single_mem[ax];
          r.accel_now        = accel_mem[ax];
          r.voltage_now      = volt_mem[ax];
          pending_records.push_back(r);
        end
      end
      default: begin
        rx_phase = PH_HEADER;
        rx_pos   = '0;
      end
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Result side: random ready, long hold-off on request, field checks
  // ---------------------------------------------------------------------------

  always @(negedge clk) begin : receiver
    int stall_left;
    if (stall_req > 0) begin
      stall_left = stall_req;
      stall_req  = 0;
    end
    if (stall_left > 0) begin
      out_tready <= 1'b0;
      stall_left--;
    end else begin
      out_tready <= no_gaps || ($urandom_range(99) >= 25);
    end
  end

  function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      err_cnt++;
      $display("%0t ns: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
    end
  endfunction

  always @(posedge clk) begin : record_check
    rec_t got;
    rec_t want;
    if (rst_n && out_tvalid && out_tready) begin
      got = rec_t'(out_tdata[REC_W-1:0]);
      if (pending_records.size() == 0) begin
        err_cnt++;
        $display("%0t ns: unexpected record, expected none, actual %h", $time, got);
      end else begin
        want = pending_records.pop_front();
        check_field("axis",             want.axis,             got.axis);
        check_field("type_code",        want.type_code,        got.type_code);
        check_field("raw_value",        want.raw_value,        got.raw_value);
        check_field("speed_now",        want.speed_now,        got.speed_now);
        check_field("multi_angle_now",  want.multi_angle_now,  got.multi_angle_now);
        check_field("single_angle_now", want.single_angle_now, got.single_angle_now);
        check_field("accel_now",        want.accel_now,        got.accel_now);
        check_field("voltage_now",      want.voltage_now,      got.voltage_now);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Request side
  // ---------------------------------------------------------------------------

  // One byte request; returns at the accepting edge with tvalid still high.
  task automatic send_byte(input logic [7:0] b);
    @(negedge clk);
    while (!no_gaps && $urandom_range(99) < 25) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    parse_rx_byte(b);
    bytes_sent++;
  endtask

  // Drop tvalid, wait for every queued record, then let the pipe empty.
  task automatic settle(input int extra);
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (pending_records.size() != 0) @(negedge clk);
    repeat (extra) @(negedge clk);
  endtask

  task automatic send_frame(input logic [7:0] addr, input logic [7:0] kind,
                            input logic [31:0] val, input logic [7:0] ck_flip = 8'h00,
                            input logic [7:0] tail = TAIL_BYTE);
    logic [7:0] ck;
    ck = HEADER_BYTE ^ addr ^ kind ^ val[31:24] ^ val[23:16] ^ val[15:8] ^ val[7:0]
         ^ ck_flip;
    send_byte(HEADER_BYTE);
    send_byte(addr);
    send_byte(kind);
    send_byte(val[31:24]);
    send_byte(val[23:16]);
    send_byte(val[15:8]);
    send_byte(val[7:0]);
    send_byte(ck);
    send_byte(tail);
  endtask

  // Only while idle: tvalid low and nothing in flight.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [7:0] val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    case (idx)
      CFG_X_ADDR:      regs.x_addr      = val;
      CFG_Y_ADDR:      regs.y_addr      = val;
      CFG_SPEED_CODE:  regs.speed_code  = val;
      CFG_MULTI_CODE:  regs.multi_code  = val;
      CFG_SINGLE_CODE: regs.single_code = val;
      CFG_ACCEL_CODE:  regs.accel_code  = val;
      CFG_VOLT_CODE:   regs.volt_code   = val;
      default: ;
    endcase
  endtask

  task automatic write_config(input cfg_t c);
    write_reg(CFG_X_ADDR,      c.x_addr);
    write_reg(CFG_Y_ADDR,      c.y_addr);
    write_reg(CFG_SPEED_CODE,  c.speed_code);
    write_reg(CFG_MULTI_CODE,  c.multi_code);
    write_reg(CFG_SINGLE_CODE, c.single_code);
    write_reg(CFG_ACCEL_CODE,  c.accel_code);
    write_reg(CFG_VOLT_CODE,   c.volt_code);
  endtask

  // Mostly good frames with random content, the rest broken frames and noise.
  task automatic send_random_frame();
    int unsigned pick;
    logic [7:0]  addr;
    logic [7:0]  kind;
    logic [31:0] val;
    pick = $urandom_range(99);
    addr = $urandom_range(1) ? regs.y_addr : regs.x_addr;
    case ($urandom_range(5))
      0:       kind = regs.speed_code;
      1:       kind = regs.multi_code;
      2:       kind = regs.single_code;
      3:       kind = regs.accel_code;
      4:       kind = regs.volt_code;
      default: kind = 8'($urandom_range(regs.volt_code, 0));
    endcase
    val = $urandom;
    case ($urandom_range(9))
      0:       val = 32'h0000_0000;
      1:       val = 32'hFFFF_FFFF;
      2:       val = 32'h8000_0000;
      3:       val = 32'h0000_8000;
      default: ;
    endcase
    if (pick < 72) begin
      send_frame(addr, kind, val);
    end else if (pick < 78) begin
      send_frame(addr, kind, val, 8'($urandom_range(255, 1)));
    end else if (pick < 83) begin
      send_frame(addr, kind, val, 8'h00, $urandom_range(1) ? HEADER_BYTE : 8'($urandom));
    end else if (pick < 87) begin
      send_frame(8'($urandom), kind, val);
    end else if (pick < 91) begin
      send_frame(addr, 8'($urandom), val);
    end else if (pick < 95) begin
      // frame cut short, next frame runs into it
      send_byte(HEADER_BYTE);
      send_byte(addr);
      repeat ($urandom_range(5)) send_byte(8'($urandom));
    end else begin
      repeat ($urandom_range(4, 1)) send_byte(8'($urandom));
    end
  endtask

  task automatic random_config();
    cfg_t c;
    c.x_addr      = 8'($urandom);
    c.y_addr      = ($urandom_range(9) == 0) ? c.x_addr : 8'($urandom);
    c.volt_code   = ($urandom_range(3) == 0) ? 8'($urandom) : 8'($urandom_range(255, 200));
    c.speed_code  = 8'($urandom_range(c.volt_code, 0));
    c.multi_code  = 8'($urandom_range(c.volt_code, 0));
    c.single_code = 8'($urandom_range(c.volt_code, 0));
    c.accel_code  = 8'($urandom_range(c.volt_code, 0));
    write_config(c);
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Reset register values: every type on both axes, value extremes, drop cases.
  task automatic test_directed();
    send_frame(RST_X_ADDR, RST_SPEED_CODE,  32'h0000_8000);
    send_frame(RST_Y_ADDR, RST_SPEED_CODE,  32'hFFFF_7FFF);
    send_frame(RST_X_ADDR, RST_MULTI_CODE,  32'h8000_0000);
    send_frame(RST_Y_ADDR, RST_MULTI_CODE,  32'h7FFF_FFFF);
    send_frame(RST_X_ADDR, RST_SINGLE_CODE, 32'hFFFF_FFFF);
    send_frame(RST_Y_ADDR, RST_ACCEL_CODE,  32'h1234_8000);
    send_frame(RST_X_ADDR, RST_VOLT_CODE,   32'h0000_FFFF);
    send_frame(RST_Y_ADDR, RST_VOLT_CODE,   32'h0000_0000);
    // type 0 matches no code: record out, stores untouched
    send_frame(RST_X_ADDR, 8'h00, 32'hDEAD_BEEF);
    // type above voltage code, unknown address, bad checksum: all dropped
    send_frame(RST_X_ADDR, RST_VOLT_CODE + 8'd1, 32'h0000_0001);
    send_frame(8'h03, RST_SPEED_CODE, 32'h0000_0002);
    send_frame(RST_Y_ADDR, RST_SPEED_CODE, 32'h0000_0003, 8'h01);
    // bad tail that looks like a header is swallowed, next frame still parses
    send_frame(RST_X_ADDR, RST_ACCEL_CODE, 32'h0000_0004, 8'h00, HEADER_BYTE);
    send_frame(RST_X_ADDR, RST_ACCEL_CODE, 32'h0000_7FFF);
    // header in the address slot is swallowed too
    send_byte(HEADER_BYTE);
    send_byte(HEADER_BYTE);
    send_frame(RST_Y_ADDR, RST_SINGLE_CODE, 32'h0000_8001);
    // noise between frames
    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(TAIL_BYTE);
    send_frame(RST_X_ADDR, RST_SPEED_CODE, 32'hFFFF_8000);
  endtask

  // Long stretch with no idling on either side.
  task automatic test_back_to_back();
    no_gaps = 1'b1;
    repeat (30) send_random_frame();
    no_gaps = 1'b0;
  endtask

  // Receiver holds off while requests keep coming; input must back up.
  task automatic test_output_stall();
    stall_req = STALL_CYCLES;
    repeat (25) send_frame($urandom_range(1) ? regs.y_addr : regs.x_addr,
                           regs.multi_code, $urandom);
  endtask

  // Sender stops until every record is in, then resumes.
  task automatic test_sender_pause();
    repeat (5) send_random_frame();
    settle(0);
    repeat (5) send_random_frame();
  endtask

  // Register extremes, equal addresses, overlapping and zero type codes.
  task automatic test_config_extremes();
    settle(DRAIN_CYCLES);
    write_config('{x_addr: 8'h00, y_addr: 8'hFF, speed_code: 8'h00, multi_code: 8'h80,
                   single_code: 8'h7F, accel_code: 8'hFF, volt_code: 8'hFF});
    send_frame(8'h00, 8'h00, 32'h8000_7FFF);
    send_frame(8'hFF, 8'h80, 32'hFFFF_FFFF);
    send_frame(8'h00, 8'h7F, 32'h0001_FFFF);
    // accel and voltage share a code: accel wins
    send_frame(8'hFF, 8'hFF, 32'h0000_8000);
    send_frame(8'h00, 8'h10, 32'h5555_AAAA);
    settle(DRAIN_CYCLES);
    write_config('{x_addr: HEADER_BYTE, y_addr: HEADER_BYTE, speed_code: 8'h03,
                   multi_code: 8'h03, single_code: 8'h03, accel_code: 8'h03,
                   volt_code: 8'h03});
    send_frame(HEADER_BYTE, 8'h03, 32'hCAFE_F00D);
    send_frame(HEADER_BYTE, 8'h02, 32'h0000_0001);
    send_frame(HEADER_BYTE, 8'h04, 32'h0000_0002);
    settle(DRAIN_CYCLES);
    // voltage code 0: only type 0 gets through
    write_config('{x_addr: 8'h01, y_addr: 8'h02, speed_code: 8'h00, multi_code: 8'h00,
                   single_code: 8'h00, accel_code: 8'h00, volt_code: 8'h00});
    send_frame(8'h02, 8'h00, 32'h0000_1234);
    send_frame(8'h01, 8'h01, 32'h0000_5678);
    settle(DRAIN_CYCLES);
    write_config('{x_addr: RST_X_ADDR, y_addr: RST_Y_ADDR, speed_code: RST_SPEED_CODE,
                   multi_code: RST_MULTI_CODE, single_code: RST_SINGLE_CODE,
                   accel_code: RST_ACCEL_CODE, volt_code: RST_VOLT_CODE});
  endtask

  // Bulk random traffic, new random register set about every CFG_EVERY bytes.
  task automatic test_random();
    int next_cfg;
    next_cfg = bytes_sent + CFG_EVERY;
    while (bytes_sent < TOTAL_BYTES) begin
      if (bytes_sent >= next_cfg) begin
        settle(DRAIN_CYCLES);
        random_config();
        next_cfg = bytes_sent + CFG_EVERY;
      end
      send_random_frame();
    end
  endtask

  initial begin
    clear_shadow();
    repeat (12) @(negedge clk);
    rst_n <= 1'b1;
    test_directed();
    test_back_to_back();
    test_output_stall();
    test_sender_pause();
    test_config_extremes();
    test_random();
    settle(DRAIN_CYCLES);
    if (err_cnt == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

>>> files.f
rtl/mffp_pkg.sv
rtl/mffp_parser.sv
rtl/mffp_record.sv
rtl/motor_feedback_frame_parser_core.sv
tb/motor_feedback_frame_parser_core_tb.sv
